// ===== src/tcrr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcrr_pkg: shared definitions for the two-class round-robin scheduler
// Field widths, slot state codes, request opcodes and the table write bundle.
// ----------------------------------------------------------------------------
package tcrr_pkg;

   localparam int SLOT_W  = 5;
   localparam int STATE_W = 3;
   localparam int STACK_W = 32;

   localparam logic [STATE_W-1:0] ST_EMPTY      = 3'd0;
   localparam logic [STATE_W-1:0] ST_READY      = 3'd1;
   localparam logic [STATE_W-1:0] ST_RUNNING    = 3'd2;
   localparam logic [STATE_W-1:0] ST_BLOCKED    = 3'd3;
   localparam logic [STATE_W-1:0] ST_TERMINATED = 3'd4;

   localparam logic OP_TICK  = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   localparam logic KIND_PROC   = 1'b0;
   localparam logic KIND_THREAD = 1'b1;

   // One write into a slot table: the state and the stack halves are enabled apart.
   typedef struct packed {
      logic               st_we;
      logic               sk_we;
      logic [STATE_W-1:0] state;
      logic [STACK_W-1:0] stack;
   } tcrr_wr_type;

endpackage

// ===== src/tcrr_slot_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcrr_slot_table: one class's slot table
// State and saved stack memories with one write and one registered read port.
// Per-slot valid bits make unwritten slots read as empty after reset.
// ----------------------------------------------------------------------------
module tcrr_slot_table
   import tcrr_pkg::*;
#(
   parameter int SLOTS = 32,
   localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
   input  logic               clock,
   input  logic               reset,
   input  tcrr_wr_type        wr,
   input  logic [IW-1:0]      wr_addr,
   input  logic [IW-1:0]      rd_addr,
   output logic [STATE_W-1:0] rd_state,
   output logic [STACK_W-1:0] rd_stack
);

   logic [STATE_W-1:0] state_mem [SLOTS];
   logic [STACK_W-1:0] stack_mem [SLOTS];
   logic [SLOTS-1:0]   valid_ff;

   logic [STATE_W-1:0] rd_state_ff;
   logic [STACK_W-1:0] rd_stack_ff;
   logic               rd_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr.st_we) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.st_we) begin
         state_mem[wr_addr] <= wr.state;
      end
      if (wr.sk_we) begin
         stack_mem[wr_addr] <= wr.stack;
      end
      rd_state_ff <= state_mem[rd_addr];
      rd_stack_ff <= stack_mem[rd_addr];
      rd_valid_ff <= valid_ff[rd_addr];
   end

   assign rd_state = rd_valid_ff ? rd_state_ff : ST_EMPTY;
   assign rd_stack = rd_stack_ff;

endmodule

// ===== src/two_class_round_robin_scheduler.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_class_round_robin_scheduler: process/thread round-robin scheduler
// Keeps a process and a thread slot table and picks the next ready slot on
// each tick, saving the outgoing stack pointer and returning the one to resume.
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | payload
//  req     | in        | req_valid / req_ready | opcode, entry_kind/index/state, stack
//  rsp     | out       | rsp_valid / rsp_ready | resume_stack, run_kind/index/valid, switched
//
//  A write request goes to the response step, which registers its response.
//  A tick reads and saves the current slot, if there is one, then scans one
//  slot per cycle over up to three passes (the rest of the current class, the
//  other class, the current class again from slot zero) with a pass-change
//  step between passes, a no-match step if no ready slot is found, and the
//  response step. After the response step the next request can be taken.
//  Reset clears the slot states through per-slot valid bits; no clearing pass.
//  req_ready is low while a request is in work; a waiting response holds only
//  the completion of the next request, not its acceptance.
// ----------------------------------------------------------------------------
module two_class_round_robin_scheduler
   import tcrr_pkg::*;
#(
   parameter int PROC_SLOTS   = 32,
   parameter int THREAD_SLOTS = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_opcode,
   input  logic               req_entry_kind,
   input  logic [SLOT_W-1:0]  req_entry_index,
   input  logic [STATE_W-1:0] req_entry_state,
   input  logic [STACK_W-1:0] req_stack_value,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [STACK_W-1:0] rsp_resume_stack,
   output logic               rsp_run_kind,
   output logic [SLOT_W-1:0]  rsp_run_index,
   output logic               rsp_run_valid,
   output logic               rsp_switched
);

   localparam int MAXS  = (PROC_SLOTS > THREAD_SLOTS) ? PROC_SLOTS : THREAD_SLOTS;
   localparam int CNT_W = $clog2(MAXS + 1);
   localparam int PW    = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;
   localparam int PIW   = (PROC_SLOTS > 1) ? $clog2(PROC_SLOTS) : 1;
   localparam int TIW   = (THREAD_SLOTS > 1) ? $clog2(THREAD_SLOTS) : 1;
   localparam logic [PW-1:0] PROC_N   = PW'(PROC_SLOTS);
   localparam logic [PW-1:0] THREAD_N = PW'(THREAD_SLOTS);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_RDCUR  = 3'd1;
   localparam logic [2:0] S_SAVE   = 3'd2;
   localparam logic [2:0] S_SCAN   = 3'd3;
   localparam logic [2:0] S_NOFIND = 3'd4;
   localparam logic [2:0] S_DONE   = 3'd5;

   localparam logic [1:0] PH_REST  = 2'd0;
   localparam logic [1:0] PH_OTHER = 2'd1;
   localparam logic [1:0] PH_WRAP  = 2'd2;

   logic [2:0]         state_ff, state_in;
   logic               cur_class_ff, cur_class_in;
   logic [SLOT_W-1:0]  cur_slot_ff, cur_slot_in;
   logic               cur_present_ff, cur_present_in;
   logic [STACK_W-1:0] sv_ff, sv_in;
   logic [STATE_W-1:0] cur_state_ff, cur_state_in;
   logic               scan_cls_ff, scan_cls_in;
   logic [1:0]         phase_ff, phase_in;
   logic [PW-1:0]      ptr_ff, ptr_in;
   logic               chk_ff, chk_in;
   logic [PW-1:0]      chk_idx_ff, chk_idx_in;
   logic [STACK_W-1:0] res_stack_ff, res_stack_in;
   logic               sw_ff, sw_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [STACK_W-1:0] rsp_resume_stack_ff, rsp_resume_stack_in;
   logic               rsp_run_kind_ff, rsp_run_kind_in;
   logic [SLOT_W-1:0]  rsp_run_index_ff, rsp_run_index_in;
   logic               rsp_run_valid_ff, rsp_run_valid_in;
   logic               rsp_switched_ff, rsp_switched_in;

   tcrr_wr_type        wr, p_wr, t_wr;
   logic               wr_cls;
   logic [PW-1:0]      wr_addr;
   logic [PW-1:0]      rd_addr;
   logic [STATE_W-1:0] p_rd_state, t_rd_state, rd_state_sel;
   logic [STACK_W-1:0] p_rd_stack, t_rd_stack, rd_stack_sel;
   logic [PW-1:0]      scan_n;
   logic [PW-1:0]      req_idx_wide;
   logic               hit;

   assign scan_n       = scan_cls_ff ? THREAD_N : PROC_N;
   assign req_idx_wide = PW'(req_entry_index);
   assign rd_state_sel = scan_cls_ff ? t_rd_state : p_rd_state;
   assign rd_stack_sel = scan_cls_ff ? t_rd_stack : p_rd_stack;
   assign hit          = chk_ff && (rd_state_sel == ST_READY);

   always_comb begin
      state_in            = state_ff;
      cur_class_in        = cur_class_ff;
      cur_slot_in         = cur_slot_ff;
      cur_present_in      = cur_present_ff;
      sv_in               = sv_ff;
      cur_state_in        = cur_state_ff;
      scan_cls_in         = scan_cls_ff;
      phase_in            = phase_ff;
      ptr_in              = ptr_ff;
      chk_in              = chk_ff;
      chk_idx_in          = chk_idx_ff;
      res_stack_in        = res_stack_ff;
      sw_in               = sw_ff;
      rsp_valid_in        = rsp_valid_ff && !rsp_ready;
      rsp_resume_stack_in = rsp_resume_stack_ff;
      rsp_run_kind_in     = rsp_run_kind_ff;
      rsp_run_index_in    = rsp_run_index_ff;
      rsp_run_valid_in    = rsp_run_valid_ff;
      rsp_switched_in     = rsp_switched_ff;
      req_ready           = 1'b0;
      wr                  = '0;
      wr_cls              = KIND_PROC;
      wr_addr             = '0;
      rd_addr             = '0;

      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               res_stack_in = '0;
               sw_in        = 1'b0;
               if (req_opcode == OP_WRITE) begin
                  // Slots past the end of the chosen table are dropped.
                  if (req_idx_wide < (req_entry_kind ? THREAD_N : PROC_N)) begin
                     wr.st_we = 1'b1;
                     wr.sk_we = 1'b1;
                     wr.state = req_entry_state;
                     wr.stack = req_stack_value;
                     wr_cls   = req_entry_kind;
                     wr_addr  = req_idx_wide;
                  end
                  state_in = S_DONE;
               end else begin
                  sv_in       = req_stack_value;
                  scan_cls_in = cur_class_ff;
                  phase_in    = PH_REST;
                  chk_in      = 1'b0;
                  ptr_in      = '0;
                  state_in    = cur_present_ff ? S_RDCUR : S_SCAN;
               end
            end
         end
         S_RDCUR: begin
            rd_addr  = PW'(cur_slot_ff);
            state_in = S_SAVE;
         end
         S_SAVE: begin
            cur_state_in = rd_state_sel;
            wr.sk_we     = 1'b1;
            wr.stack     = sv_ff;
            wr.st_we     = (rd_state_sel == ST_RUNNING);
            wr.state     = ST_READY;
            wr_cls       = cur_class_ff;
            wr_addr      = PW'(cur_slot_ff);
            ptr_in       = PW'(cur_slot_ff) + PW'(1);
            state_in     = S_SCAN;
         end
         S_SCAN: begin
            // Reads are issued one slot ahead; the registered data is checked in the
            // next cycle against the slot recorded in chk_idx_ff.
            if (hit) begin
               wr.st_we       = 1'b1;
               wr.state       = ST_RUNNING;
               wr_cls         = scan_cls_ff;
               wr_addr        = chk_idx_ff;
               cur_class_in   = scan_cls_ff;
               cur_slot_in    = chk_idx_ff[SLOT_W-1:0];
               cur_present_in = 1'b1;
               res_stack_in   = rd_stack_sel;
               sw_in          = 1'b1;
               chk_in         = 1'b0;
               state_in       = S_DONE;
            end else if (ptr_ff < scan_n) begin
               rd_addr    = ptr_ff;
               chk_in     = 1'b1;
               chk_idx_in = ptr_ff;
               ptr_in     = ptr_ff + PW'(1);
            end else begin
               chk_in = 1'b0;
               ptr_in = '0;
               case (phase_ff)
                  PH_REST: begin
                     phase_in    = PH_OTHER;
                     scan_cls_in = ~cur_class_ff;
                  end
                  PH_OTHER: begin
                     phase_in    = PH_WRAP;
                     scan_cls_in = cur_class_ff;
                  end
                  default: begin
                     state_in = S_NOFIND;
                  end
               endcase
            end
         end
         S_NOFIND: begin
            res_stack_in = sv_ff;
            sw_in        = 1'b0;
            if (cur_present_ff && cur_state_ff != ST_BLOCKED
                && cur_state_ff != ST_TERMINATED) begin
               wr.st_we = 1'b1;
               wr.state = ST_RUNNING;
               wr_cls   = cur_class_ff;
               wr_addr  = PW'(cur_slot_ff);
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in        = 1'b1;
               rsp_resume_stack_in = res_stack_ff;
               rsp_run_kind_in     = cur_class_ff;
               rsp_run_index_in    = cur_present_ff ? cur_slot_ff : '0;
               rsp_run_valid_in    = cur_present_ff;
               rsp_switched_in     = sw_ff;
               state_in            = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      p_wr       = wr;
      t_wr       = wr;
      p_wr.st_we = wr.st_we && (wr_cls == KIND_PROC);
      p_wr.sk_we = wr.sk_we && (wr_cls == KIND_PROC);
      t_wr.st_we = wr.st_we && (wr_cls == KIND_THREAD);
      t_wr.sk_we = wr.sk_we && (wr_cls == KIND_THREAD);
   end

   tcrr_slot_table #(.SLOTS(PROC_SLOTS)) u_proc_table (
      .clock    (clock),
      .reset    (reset),
      .wr       (p_wr),
      .wr_addr  (wr_addr[PIW-1:0]),
      .rd_addr  (rd_addr[PIW-1:0]),
      .rd_state (p_rd_state),
      .rd_stack (p_rd_stack)
   );

   tcrr_slot_table #(.SLOTS(THREAD_SLOTS)) u_thread_table (
      .clock    (clock),
      .reset    (reset),
      .wr       (t_wr),
      .wr_addr  (wr_addr[TIW-1:0]),
      .rd_addr  (rd_addr[TIW-1:0]),
      .rd_state (t_rd_state),
      .rd_stack (t_rd_stack)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         cur_class_ff   <= KIND_PROC;
         cur_slot_ff    <= '0;
         cur_present_ff <= 1'b0;
         chk_ff         <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         cur_class_ff   <= cur_class_in;
         cur_slot_ff    <= cur_slot_in;
         cur_present_ff <= cur_present_in;
         chk_ff         <= chk_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sv_ff               <= sv_in;
      cur_state_ff        <= cur_state_in;
      scan_cls_ff         <= scan_cls_in;
      phase_ff            <= phase_in;
      ptr_ff              <= ptr_in;
      chk_idx_ff          <= chk_idx_in;
      res_stack_ff        <= res_stack_in;
      sw_ff               <= sw_in;
      rsp_resume_stack_ff <= rsp_resume_stack_in;
      rsp_run_kind_ff     <= rsp_run_kind_in;
      rsp_run_index_ff    <= rsp_run_index_in;
      rsp_run_valid_ff    <= rsp_run_valid_in;
      rsp_switched_ff     <= rsp_switched_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_resume_stack = rsp_resume_stack_ff;
   assign rsp_run_kind     = rsp_run_kind_ff;
   assign rsp_run_index    = rsp_run_index_ff;
   assign rsp_run_valid    = rsp_run_valid_ff;
   assign rsp_switched     = rsp_switched_ff;

`ifndef SYNTHESIS
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted while the previous one is still in work");

   a_switch_has_current: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_switched_ff) |-> rsp_run_valid_ff)
      else $error("switch reported without a current entry");

   a_idle_index_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_run_valid_ff) |-> (rsp_run_index_ff == '0 && !rsp_switched_ff))
      else $error("response without a current entry carries an index or a switch");

   a_hit_grants: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN && hit) |=> (cur_present_ff && state_ff == S_DONE && sw_ff))
      else $error("ready slot found but not made current");
`endif

endmodule
